// ===== rtl/phd_pkg.sv =====
// shared types, constants and codes of the piezo hit detector
package phd_pkg;

   localparam int SAMPLE_WIDTH = 10;
   localparam int TIME_WIDTH = 32;
   localparam int SLOT_IDX_WIDTH = 8;
   localparam int FACTOR_WIDTH = 8;
   localparam int THR_WIDTH = SAMPLE_WIDTH + 1;
   localparam int WINDOW_WIDTH = 16;
   localparam int FUNC_WIDTH = 2;
   localparam int SLOT_SHIFT = 10;
   localparam int FACTOR_SHIFT = 8;
   localparam int TABLE_DEPTH_DEFAULT = 256;

   localparam logic [SAMPLE_WIDTH-1:0] BASE_RESET = SAMPLE_WIDTH'(3);
   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = WINDOW_WIDTH'(500);
   localparam logic [FACTOR_WIDTH-1:0] FACTOR_MAX = '1;
   localparam logic [THR_WIDTH-1:0] CAL_BLOCK = THR_WIDTH'(1) << SAMPLE_WIDTH;

   localparam logic [FUNC_WIDTH-1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_TABLE_WRITE = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_TABLE_READ = 2'd2;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = WINDOW_WIDTH;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CALIBRATE_MODE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BASE_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAPTURE_WINDOW = 2'd2;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0] func;
      logic [SAMPLE_WIDTH-1:0] sample_level;
      logic [TIME_WIDTH-1:0] time_us;
      logic [SLOT_IDX_WIDTH-1:0] slot_index;
      logic [FACTOR_WIDTH-1:0] slot_value;
   } req_word_type;

   typedef struct packed {
      logic hit_valid;
      logic [SAMPLE_WIDTH-1:0] hit_velocity;
      logic save_request;
      logic [FACTOR_WIDTH-1:0] read_factor;
      logic [THR_WIDTH-1:0] active_threshold;
   } rsp_word_type;

   typedef struct packed {
      logic clear_step;
      logic load_item;
      logic setup;
      logic window;
      logic calc;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/phd_if.sv =====
// request and response channel interfaces
interface phd_req_if;
   logic valid;
   logic ready;
   phd_pkg::req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface phd_rsp_if;
   logic valid;
   logic ready;
   phd_pkg::rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// ===== rtl/phd_ctrl.sv =====
// controller state machine sequencing clear, load, lookup, divide and commit
module phd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  phd_pkg::status_type  status,
   output phd_pkg::cmd_type     cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_LOAD  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CALC  = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   localparam int DivSteps = phd_pkg::FACTOR_SHIFT;
   localparam int CntWidth = $clog2(DivSteps);

   logic [2:0] state_ff, state_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.setup = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.window = 1'b1;
            state_in = S_CALC;
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + CntWidth'(1);
            if (cnt_ff == CntWidth'(DivSteps - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/phd_datapath.sv =====
// datapath: config registers, detector state, decay table, divider and response register
module phd_datapath #(
   parameter int TableDepth = phd_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  phd_pkg::cmd_type                      cmd,
   output phd_pkg::status_type                   status,
   input  phd_pkg::req_word_type                 req_word,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output phd_pkg::rsp_word_type                 rsp_word,
   input  logic                                  csr_write_enable,
   input  logic [phd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [phd_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   localparam int SW = phd_pkg::SAMPLE_WIDTH;
   localparam int TW = phd_pkg::TIME_WIDTH;
   localparam int FW = phd_pkg::FACTOR_WIDTH;
   localparam int HW = phd_pkg::THR_WIDTH;
   localparam int FS = phd_pkg::FACTOR_SHIFT;
   localparam int SS = phd_pkg::SLOT_SHIFT;
   localparam int AW = $clog2(TableDepth);
   localparam int IdxExtWidth = (AW > phd_pkg::SLOT_IDX_WIDTH) ? AW : phd_pkg::SLOT_IDX_WIDTH;
   localparam int NumWidth = SW + FS + 1;
   localparam int DenWidth = SW + FS - 1;
   localparam int ProdWidth = FW + SW;

   // configuration
   logic calibrate_ff;
   logic [SW-1:0] base_ff;
   logic [phd_pkg::WINDOW_WIDTH-1:0] window_ff;

   // detector state
   logic capturing_ff, hit_recent_ff, changed_ff;
   logic [TW-1:0] capture_start_ff, peak_time_ff;
   logic [SW-1:0] peak_ff;

   // latched word
   phd_pkg::req_word_type item_ff;

   // per-item work registers
   logic [TW-1:0] us_ff, limit_ff;
   logic within_ff, over_ff, in_win_ff;
   logic [FW-1:0] rd_data_ff;
   logic [ProdWidth-1:0] prod_ff;
   logic [NumWidth-1:0] rem_ff;
   logic [DenWidth-1:0] den_ff;
   logic [FW-1:0] quo_ff;
   logic sat_ff;

   // table and clearing sweep
   logic [FW-1:0] decay_table_mem [TableDepth];
   logic [AW-1:0] clr_cnt_ff;

   logic rsp_valid_ff;
   phd_pkg::rsp_word_type rsp_word_ff;

   logic [IdxExtWidth-1:0] idx_ext;
   logic idx_ok;
   logic [AW-1:0] idx_addr, slot_addr, mem_ra, mem_wa;
   logic mem_we;
   logic [FW-1:0] mem_wd;
   logic [NumWidth-1:0] num_c;
   logic [FW-1:0] ratio;
   logic [TW-1:0] window_diff;

   // commit logic
   phd_pkg::rsp_word_type out_c;
   logic learn_we;
   logic [HW-1:0] thr_c;
   logic capturing_in, hit_recent_in, changed_in;
   logic [TW-1:0] capture_start_in, peak_time_in;
   logic [SW-1:0] peak_in;

   assign idx_ext = IdxExtWidth'(item_ff.slot_index);
   assign idx_ok = 32'(item_ff.slot_index) < 32'(TableDepth);
   assign idx_addr = idx_ext[AW-1:0];
   assign slot_addr = us_ff[SS +: AW];
   assign mem_ra = (item_ff.func == phd_pkg::FUNC_SAMPLE) ? slot_addr : idx_addr;
   assign ratio = sat_ff ? phd_pkg::FACTOR_MAX : quo_ff;
   assign window_diff = limit_ff - item_ff.time_us;
   assign num_c = NumWidth'({item_ff.sample_level, FS'(0)}) + NumWidth'(peak_ff)
                  - NumWidth'(1);

   assign status.clear_last = (clr_cnt_ff == AW'(TableDepth - 1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   always_comb begin
      out_c = '0;
      learn_we = 1'b0;
      thr_c = '0;
      capturing_in = capturing_ff;
      hit_recent_in = hit_recent_ff;
      changed_in = changed_ff;
      capture_start_in = capture_start_ff;
      peak_time_in = peak_time_ff;
      peak_in = peak_ff;
      priority if (item_ff.func == phd_pkg::FUNC_TABLE_READ) begin
         if (idx_ok) out_c.read_factor = rd_data_ff;
      end else if (item_ff.func == phd_pkg::FUNC_SAMPLE) begin
         if (capturing_ff) begin
            if (within_ff) begin
               if (item_ff.sample_level > peak_ff) begin
                  peak_in = item_ff.sample_level;
                  peak_time_in = item_ff.time_us;
               end
            end else begin
               capturing_in = 1'b0;
               out_c.hit_valid = 1'b1;
               out_c.hit_velocity = peak_ff;
               hit_recent_in = 1'b1;
               changed_in = 1'b0;
            end
         end else begin
            thr_c = HW'(base_ff);
            if (hit_recent_ff) begin
               if (calibrate_ff) begin
                  if (over_ff) begin
                     hit_recent_in = 1'b0;
                     out_c.save_request = changed_ff;
                  end else if (ratio > rd_data_ff) begin
                     changed_in = 1'b1;
                     learn_we = 1'b1;
                  end
                  thr_c = phd_pkg::CAL_BLOCK;
               end else begin
                  if (over_ff) begin
                     hit_recent_in = 1'b0;
                  end else if (in_win_ff) begin
                     thr_c = HW'(base_ff) + HW'(peak_ff);
                  end else begin
                     thr_c = HW'(base_ff) + HW'(prod_ff[ProdWidth-1:FS]);
                  end
               end
            end
            out_c.active_threshold = thr_c;
            if (HW'(item_ff.sample_level) >= thr_c) begin
               capturing_in = 1'b1;
               capture_start_in = item_ff.time_us;
               peak_in = item_ff.sample_level;
               if (item_ff.sample_level != '0) peak_time_in = item_ff.time_us;
            end
         end
      end else begin
         // table writes and the unused code give an all-zero word
         out_c = '0;
      end
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = idx_addr;
      mem_wd = item_ff.slot_value;
      priority if (cmd.clear_step) begin
         mem_we = 1'b1;
         mem_wa = clr_cnt_ff;
         mem_wd = '0;
      end else if (cmd.finish && learn_we) begin
         mem_we = 1'b1;
         mem_wa = slot_addr;
         mem_wd = ratio;
      end else if (cmd.finish && item_ff.func == phd_pkg::FUNC_TABLE_WRITE && idx_ok) begin
         mem_we = 1'b1;
      end else begin
         mem_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) decay_table_mem[mem_wa] <= mem_wd;
      rd_data_ff <= decay_table_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calibrate_ff <= 1'b0;
         base_ff <= phd_pkg::BASE_RESET;
         window_ff <= phd_pkg::WINDOW_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            phd_pkg::CSR_CALIBRATE_MODE: calibrate_ff <= csr_write_data[0];
            phd_pkg::CSR_BASE_THRESHOLD: base_ff <= csr_write_data[SW-1:0];
            phd_pkg::CSR_CAPTURE_WINDOW: window_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capturing_ff <= 1'b0;
         hit_recent_ff <= 1'b0;
         changed_ff <= 1'b0;
         capture_start_ff <= '0;
         peak_time_ff <= '0;
         peak_ff <= '0;
      end else if (cmd.finish) begin
         capturing_ff <= capturing_in;
         hit_recent_ff <= hit_recent_in;
         changed_ff <= changed_in;
         capture_start_ff <= capture_start_in;
         peak_time_ff <= peak_time_in;
         peak_ff <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) rsp_word_ff <= out_c;
      if (cmd.load_item) item_ff <= req_word;
      if (cmd.setup) begin
         us_ff <= item_ff.time_us - peak_time_ff;
         limit_ff <= capture_start_ff + TW'(window_ff);
      end
      if (cmd.window) begin
         within_ff <= !window_diff[TW-1];
         over_ff <= us_ff[TW-1:SS] >= (TW - SS)'(TableDepth);
         in_win_ff <= us_ff < TW'(window_ff);
      end
      if (cmd.calc) begin
         prod_ff <= ProdWidth'(rd_data_ff) * ProdWidth'(peak_ff);
         // ceil(level*256/peak) saturates when it reaches 256
         sat_ff <= (peak_ff == '0) || (num_c >= NumWidth'({peak_ff, FS'(0)}));
         rem_ff <= num_c;
         den_ff <= {peak_ff, (FS - 1)'(0)};
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem_ff >= NumWidth'(den_ff)) begin
            rem_ff <= rem_ff - NumWidth'(den_ff);
            quo_ff <= {quo_ff[FW-2:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[FW-2:0], 1'b0};
         end
         den_ff <= den_ff >> 1;
      end
   end

endmodule

// ===== rtl/piezo_hit_detector_learned_decay_top.sv =====
// Piezo hit detector with learned decay threshold. Each request word is a timestamped
// sample or a decay-table write or read, and each gives exactly one response word. A word
// passes from acceptance through the load, read and calc states and the 8-step
// restoring divider that forms the calibration ratio, then waits in the done state until
// the response register is free; a new word is accepted only once the last is through,
// and the next word is accepted while a response waits to be taken. After reset the decay
// table is cleared one entry per cycle, so requests are accepted only once the clear is
// done; configuration writes are taken at any time and should be made only while no word is in flight.
module piezo_hit_detector_learned_decay_top #(
   parameter int TableDepth = phd_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   phd_req_if.sink                               req_chan,
   phd_rsp_if.source                             rsp_chan,
   input  logic                                  csr_write_enable,
   input  logic [phd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [phd_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   phd_pkg::cmd_type cmd;
   phd_pkg::status_type status;

   phd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   phd_datapath #(
      .TableDepth (TableDepth)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_word         (req_chan.word),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_word         (rsp_chan.word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

endmodule

// ===== sim/hit_detector_checker.sv =====
// response checker for the piezo hit detector: tracks its state and compares every response word
module hit_detector_checker
   import phd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  req_word_type               req_word,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  rsp_word_type               rsp_word,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int                         error_count,
   output int                         outstanding,
   output int                         checked_count,
   output int                         hit_count,
   output int                         save_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS = TABLE_DEPTH_DEFAULT;

   // detector state as the block should hold it
   logic [FACTOR_WIDTH-1:0] decay_factor [TABLE_SLOTS];
   logic capture_on;
   logic [TIME_WIDTH-1:0] capture_t0;
   logic [SAMPLE_WIDTH-1:0] peak_lvl;
   logic [TIME_WIDTH-1:0] peak_t;
   logic ringing;
   logic learned_new;

   logic cal_on;
   logic [SAMPLE_WIDTH-1:0] base_lvl;
   logic [WINDOW_WIDTH-1:0] window_len;

   rsp_word_type predicted_q [$];
   int errors;
   int checked;
   int hits;
   int saves;

   function automatic rsp_word_type predict_response(input req_word_type w);
      rsp_word_type r;
      logic [31:0] margin;
      logic [31:0] since_peak;
      logic [31:0] slot;
      logic [31:0] ratio;
      logic [THR_WIDTH-1:0] thr;
      r = '0;
      thr = '0;
      if (w.func == FUNC_TABLE_WRITE) begin
         decay_factor[w.slot_index] = w.slot_value;
      end else if (w.func == FUNC_TABLE_READ) begin
         r.read_factor = decay_factor[w.slot_index];
      end else if (w.func == FUNC_SAMPLE) begin
         if (capture_on) begin
            // wrap-safe: inside while window end minus time has its top bit clear
            margin = capture_t0 + 32'(window_len) - w.time_us;
            if (!margin[31]) begin
               if (w.sample_level > peak_lvl) begin
                  peak_lvl = w.sample_level;
                  peak_t = w.time_us;
               end
            end else begin
               capture_on = 1'b0;
               r.hit_valid = 1'b1;
               r.hit_velocity = peak_lvl;
               ringing = 1'b1;
               learned_new = 1'b0;
            end
         end else begin
            thr = THR_WIDTH'(base_lvl);
            if (ringing) begin
               since_peak = w.time_us - peak_t;
               slot = since_peak >> SLOT_SHIFT;
               if (slot >= TABLE_SLOTS) begin
                  ringing = 1'b0;
                  if (cal_on && learned_new) r.save_request = 1'b1;
               end else if (cal_on) begin
                  if (peak_lvl == '0) begin
                     ratio = 32'(FACTOR_MAX);
                  end else begin
                     ratio = ((32'(w.sample_level) << FACTOR_SHIFT) + 32'(peak_lvl) - 32'd1)
                             / 32'(peak_lvl);
                  end
                  if (ratio > 32'(FACTOR_MAX)) ratio = 32'(FACTOR_MAX);
                  if (ratio > 32'(decay_factor[slot[7:0]])) begin
                     learned_new = 1'b1;
                     decay_factor[slot[7:0]] = ratio[FACTOR_WIDTH-1:0];
                  end
               end else if (since_peak < 32'(window_len)) begin
                  thr = thr + THR_WIDTH'(peak_lvl);
               end else begin
                  thr = thr + THR_WIDTH'((32'(decay_factor[slot[7:0]]) * 32'(peak_lvl))
                                         >> FACTOR_SHIFT);
               end
               // calibration blocks triggering, also on the sample that ends ring-out
               if (cal_on) thr = CAL_BLOCK;
            end
            if (THR_WIDTH'(w.sample_level) >= thr) begin
               capture_on = 1'b1;
               capture_t0 = w.time_us;
               peak_lvl = '0;
               // a zero-level trigger keeps the old peak time
               if (w.sample_level > '0) begin
                  peak_lvl = w.sample_level;
                  peak_t = w.time_us;
               end
            end
            r.active_threshold = thr;
         end
      end
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errors++;
         $error("response %0d: %s expected %0d, got %0d", checked, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) decay_factor[i] = '0;
         capture_on = 1'b0;
         capture_t0 = '0;
         peak_lvl = '0;
         peak_t = '0;
         ringing = 1'b0;
         learned_new = 1'b0;
         cal_on = 1'b0;
         base_lvl = BASE_RESET;
         window_len = WINDOW_RESET;
         predicted_q.delete();
         errors = 0;
         checked = 0;
         hits = 0;
         saves = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CALIBRATE_MODE: cal_on = csr_write_data[0];
               CSR_BASE_THRESHOLD: base_lvl = csr_write_data[SAMPLE_WIDTH-1:0];
               CSR_CAPTURE_WINDOW: window_len = csr_write_data[WINDOW_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predicted_q.push_back(predict_response(req_word));
         if (rsp_valid && rsp_ready) begin
            if (predicted_q.size() == 0) begin
               errors++;
               $error("response word arrived with nothing expected");
            end else begin
               want = predicted_q.pop_front();
               check_field("hit_valid", want.hit_valid, rsp_word.hit_valid);
               check_field("hit_velocity", want.hit_velocity, rsp_word.hit_velocity);
               check_field("save_request", want.save_request, rsp_word.save_request);
               check_field("read_factor", want.read_factor, rsp_word.read_factor);
               check_field("active_threshold", want.active_threshold,
                           rsp_word.active_threshold);
               checked++;
               if (want.hit_valid) hits++;
               if (want.save_request) saves++;
            end
         end
      end
      error_count <= errors;
      outstanding <= predicted_q.size();
      checked_count <= checked;
      hit_count <= hits;
      save_count <= saves;
   end

endmodule

// ===== sim/tb_top.sv =====
// top of the piezo hit detector testbench: clock, reset, stimulus and verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import phd_pkg::*;

   localparam logic [FUNC_WIDTH-1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   // ring-out lasts this long after the peak
   localparam int unsigned RING_SPAN_US = 256 * 1024;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data;

   phd_req_if req_chan ();
   phd_rsp_if rsp_chan ();

   int error_count;
   int outstanding;
   int checked_count;
   int hit_count;
   int save_count;

   int words_sent;
   int settings_used;
   int cycle_count;
   int send_gap_pct;
   int rsp_stall_pct;
   int rsp_hold;
   bit quiet_tail;
   logic [TIME_WIDTH-1:0] now_us;
   logic [SAMPLE_WIDTH-1:0] cur_base;
   logic [WINDOW_WIDTH-1:0] cur_window;

   piezo_hit_detector_learned_decay_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   hit_detector_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_word         (req_chan.word),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_word         (rsp_chan.word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .outstanding      (outstanding),
      .checked_count    (checked_count),
      .hit_count        (hit_count),
      .save_count       (save_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // response side stalls in bursts
   always @(negedge clock) begin
      if (quiet_tail) begin
         rsp_chan.ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if ($urandom_range(99) < rsp_stall_pct) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold <= $urandom_range(0, 18);
      end else begin
         rsp_chan.ready <= 1'b1;
         rsp_hold <= $urandom_range(0, 24);
      end
   end

   task automatic send_word(input req_word_type w);
      @(negedge clock);
      if (!quiet_tail && $urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.word <= w;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
   endtask

   task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] lvl,
                              input logic [TIME_WIDTH-1:0] t);
      req_word_type w;
      w.func = FUNC_SAMPLE;
      w.sample_level = lvl;
      w.time_us = t;
      w.slot_index = SLOT_IDX_WIDTH'($urandom);
      w.slot_value = FACTOR_WIDTH'($urandom);
      send_word(w);
   endtask

   task automatic send_table(input logic [FUNC_WIDTH-1:0] func,
                             input logic [SLOT_IDX_WIDTH-1:0] idx,
                             input logic [FACTOR_WIDTH-1:0] val);
      req_word_type w;
      w.func = func;
      w.sample_level = SAMPLE_WIDTH'($urandom);
      w.time_us = $urandom;
      w.slot_index = idx;
      w.slot_value = val;
      send_word(w);
   endtask

   // hold off the sender until every outstanding word has its response
   task automatic drain_responses();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic apply_settings(input int unsigned cal, input int unsigned base,
                                 input int unsigned window);
      drain_responses();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_CALIBRATE_MODE;
      csr_write_data <= CSR_DATA_WIDTH'(cal);
      @(negedge clock);
      csr_index <= CSR_BASE_THRESHOLD;
      csr_write_data <= CSR_DATA_WIDTH'(base);
      @(negedge clock);
      csr_index <= CSR_CAPTURE_WINDOW;
      csr_write_data <= CSR_DATA_WIDTH'(window);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cur_base = SAMPLE_WIDTH'(base);
      cur_window = WINDOW_WIDTH'(window);
      settings_used++;
   endtask

   function automatic logic [SAMPLE_WIDTH-1:0] quiet_level();
      if (cur_base == '0) return '0;
      if ($urandom_range(9) == 0) return SAMPLE_WIDTH'($urandom);
      return SAMPLE_WIDTH'($urandom_range(0, cur_base - 1));
   endfunction

   // quiet samples, a trigger, peak search, the word that ends it, then ring-out samples and table words
   task automatic random_strike();
      logic [TIME_WIDTH-1:0] start_us;
      int unsigned pick;
      repeat ($urandom_range(0, 3)) begin
         now_us += $urandom_range(1, 4000);
         send_sample(quiet_level(), now_us);
      end
      now_us += $urandom_range(1, 5000);
      send_sample(SAMPLE_WIDTH'($urandom_range(cur_base, 1023)), now_us);
      start_us = now_us;
      repeat ($urandom_range(0, 5)) begin
         if ($urandom_range(4) == 0) begin
            send_table(FUNC_TABLE_READ, SLOT_IDX_WIDTH'($urandom), '0);
         end else begin
            now_us += $urandom_range(0, cur_window / 3);
            if (now_us - start_us > 32'(cur_window)) now_us = start_us + 32'(cur_window);
            send_sample(SAMPLE_WIDTH'($urandom), now_us);
         end
      end
      now_us = start_us + 32'(cur_window)
               + (($urandom_range(3) == 0) ? 32'd1 : 32'($urandom_range(1, 64)));
      send_sample(SAMPLE_WIDTH'($urandom), now_us);
      repeat ($urandom_range(2, 14)) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_table($urandom_range(1) ? FUNC_TABLE_WRITE : FUNC_TABLE_READ,
                       SLOT_IDX_WIDTH'($urandom), FACTOR_WIDTH'($urandom));
         end else if (pick < 13) begin
            send_table(FUNC_UNUSED, SLOT_IDX_WIDTH'($urandom), FACTOR_WIDTH'($urandom));
         end else begin
            case ($urandom_range(2))
               0: now_us += $urandom_range(1, 32'(cur_window) + 1);
               1: now_us += $urandom_range(1, 8192);
               default: now_us += $urandom_range(1, 40000);
            endcase
            send_sample(SAMPLE_WIDTH'($urandom_range(0, 1023) >> $urandom_range(0, 5)),
                        now_us);
         end
      end
      pick = $urandom_range(9);
      if (pick < 6) begin
         now_us += RING_SPAN_US + $urandom_range(0, 50000);
         send_sample(quiet_level(), now_us);
      end else if (pick == 6) begin
         now_us += $urandom;
      end
   endtask

   task automatic run_phase(input int unsigned cal, input int unsigned base,
                            input int unsigned window, input int items,
                            input int gap_pct, input int stall_pct);
      int stop_at;
      int drain_at;
      bit drained;
      apply_settings(cal, base, window);
      send_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      stop_at = words_sent + items;
      drain_at = words_sent + $urandom_range(items / 4, items * 3 / 4);
      drained = 1'b0;
      now_us = $urandom;
      while (words_sent < stop_at) begin
         random_strike();
         if (!drained && words_sent >= drain_at) begin
            drain_responses();
            drained = 1'b1;
         end
      end
   endtask

   initial begin
      req_word_type w;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.word = '0;
      rsp_chan.ready = 1'b0;
      rsp_hold = 0;
      quiet_tail = 1'b0;
      send_gap_pct = 10;
      rsp_stall_pct = 10;
      words_sent = 0;
      settings_used = 0;
      cycle_count = 0;
      now_us = '0;
      cur_base = BASE_RESET;
      cur_window = WINDOW_RESET;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset settings: base 3, window 500
      w.func = FUNC_UNUSED;
      w.sample_level = '1;
      w.time_us = '1;
      w.slot_index = '1;
      w.slot_value = '1;
      send_word(w);
      send_table(FUNC_TABLE_WRITE, 8'd255, 8'd255);
      send_table(FUNC_TABLE_WRITE, 8'd0, 8'd128);
      send_table(FUNC_TABLE_READ, 8'd255, 8'd0);
      send_table(FUNC_TABLE_READ, 8'd0, 8'd0);
      send_sample(10'd2, 32'd100);
      send_sample(10'd1023, 32'd200);
      send_table(FUNC_TABLE_READ, 8'd0, 8'd0);
      // exactly at the window end is still inside
      send_sample(10'd5, 32'd700);
      send_sample(10'd0, 32'd701);
      send_sample(10'd1023, 32'd900);
      send_sample(10'd600, 32'd1000);
      send_sample(10'd0, 32'd1501);
      send_sample(10'd599, 32'd1000 + 255 * 1024);
      send_sample(10'd0, 32'd1000 + 256 * 1024);
      // capture window across the timestamp wrap
      send_sample(10'd4, 32'hFFFF_FF00);
      send_sample(10'd9, 32'h0000_00F0);
      send_sample(10'd1, 32'h0000_0100);
      send_sample(10'd0, 32'h0010_0000);

      // calibration with zero base, one-microsecond window
      apply_settings(1, 0, 1);
      send_sample(10'd0, 32'd10000);
      send_sample(10'd0, 32'd10002);
      send_sample(10'd500, 32'd10003);
      send_sample(10'd1023, 32'd10003 + 1024);
      send_sample(10'd0, 32'd310000);
      send_sample(10'd1, 32'd400000);
      send_sample(10'd0, 32'd400002);
      send_sample(10'd3, 32'd400010);
      send_sample(10'd0, 32'd400000 + RING_SPAN_US);

      run_phase(0, 3, 500, 250, 20, 20);
      run_phase(1, 20, 300, 200, 10, 30);
      run_phase(0, 20, 300, 150, 0, 0);
      run_phase(0, 1023, 65535, 100, 30, 10);
      run_phase(1, 0, 1, 150, 15, 15);
      run_phase(0, 0, 1, 120, 5, 40);
      run_phase(0, $urandom_range(1, 200), $urandom_range(1, 5000), 200, 20, 20);
      run_phase(1, $urandom_range(0, 100), $urandom_range(1, 2000), 150, 10, 10);
      quiet_tail = 1'b1;
      run_phase(0, 8, 200, 150, 0, 0);
      drain_responses();
      repeat (20) @(posedge clock);

      $display("tb_top: %0d words sent under %0d register settings, %0d responses checked",
               words_sent, settings_used, checked_count);
      $display("tb_top: %0d hits and %0d calibration save requests predicted",
               hit_count, save_count);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ===== piezo_hit_detector_learned_decay_top.f =====
rtl/phd_pkg.sv
rtl/phd_if.sv
rtl/phd_ctrl.sv
rtl/phd_datapath.sv
rtl/piezo_hit_detector_learned_decay_top.sv
sim/hit_detector_checker.sv
sim/tb_top.sv
